FILE: src/lrs_pkg.sv
// Shared constants, result type and helper functions of the log record scanner.
package lrs_pkg;

  // Log region size in bytes; the byte at LOG_BYTES-1 always closes a scan.
  localparam int LOG_BYTES = 16384;

  localparam logic [15:0] MAGIC_WORD = 16'h4C47;
  localparam logic [31:0] FNV_BASIS  = 32'h811C9DC5;

  // Result buffer between the scanner and the output channel.
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

  // Result kinds.
  localparam logic KIND_RECORD = 1'b0;
  localparam logic KIND_END    = 1'b1;

  // Stop reasons carried in the status field.
  localparam logic [2:0] ST_CLEAN    = 3'd0;
  localparam logic [2:0] ST_ERASED   = 3'd1;
  localparam logic [2:0] ST_BAD_MAGIC = 3'd2;
  localparam logic [2:0] ST_BAD_LEN  = 3'd3;
  localparam logic [2:0] ST_OVERRUN  = 3'd4;
  localparam logic [2:0] ST_BAD_SUM  = 3'd5;

  // Configuration register indexes.
  localparam logic [1:0] CFG_STRICT = 2'd0;
  localparam logic [1:0] CFG_MAXLEN = 2'd1;
  localparam logic [1:0] CFG_SELECT = 2'd2;

  typedef struct packed {
    logic        kind;
    logic [2:0]  status;
    logic [10:0] idx;
    logic [15:0] len;
    logic [14:0] off;
    logic        sel;
    logic        rlast;
  } result_t;

  // One FNV-1a step; the prime 16777619 is 2^24 + 2^8 + 2^7 + 2^4 + 2^1 + 1.
  function automatic logic [31:0] fnv_step(logic [31:0] sum, logic [7:0] b);
    logic [31:0] x;
    x = sum ^ {24'b0, b};
    return (x << 24) + (x << 8) + (x << 7) + (x << 4) + (x << 1) + x;
  endfunction

  // Record span: header plus payload, rounded up to a 4-byte boundary.
  function automatic logic [16:0] span_of(logic [15:0] len);
    return ({1'b0, len} + 17'd11) & ~17'd3;
  endfunction

endpackage

FILE: src/lrs_result_fifo.sv
// Eight-entry result buffer that takes up to two results per cycle.
module lrs_result_fifo (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [1:0]                        push_cnt_i,
  input  lrs_pkg::result_t                  push0_i,
  input  lrs_pkg::result_t                  push1_i,
  input  logic                              pop_i,
  output lrs_pkg::result_t                  head_o,
  output logic [lrs_pkg::FIFO_CNT_W-1:0]    count_o
);

  lrs_pkg::result_t                mem_q [lrs_pkg::FIFO_DEPTH];
  logic [lrs_pkg::FIFO_PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [lrs_pkg::FIFO_CNT_W-1:0]  cnt_q, cnt_d;
  logic [lrs_pkg::FIFO_PTR_W-1:0]  wr_ptr_nx;

  assign wr_ptr_nx = wr_ptr_q + lrs_pkg::FIFO_PTR_W'(1);
  assign wr_ptr_d  = wr_ptr_q + lrs_pkg::FIFO_PTR_W'(push_cnt_i);
  assign rd_ptr_d  = rd_ptr_q + lrs_pkg::FIFO_PTR_W'(pop_i);
  assign cnt_d     = cnt_q + lrs_pkg::FIFO_CNT_W'(push_cnt_i)
                   - lrs_pkg::FIFO_CNT_W'(pop_i);

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_ptr_nx] <= push1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  assign head_o  = mem_q[rd_ptr_q];
  assign count_o = cnt_q;

endmodule

FILE: src/log_record_scanner_unit.sv
// Top level of the log record scanner: byte stage, record parser and result output.
//
// The scanner takes one log byte per beat and can accept a beat in every cycle. Each
// accepted byte is first held in an input register; in the next cycle the parser
// updates its header, checksum and offset state and writes zero, one or two results
// into an eight-entry result buffer, whose head drives the output channel, so a
// result always passes through the buffer before it appears. The output channel moves
// one result per cycle while the receiver is ready; a record completed by the closing
// byte of a region gives a record result and an end result, and only this case
// produces more results than bytes. The input is held off while the buffer, counting
// the byte in the input register, has fewer than two free entries. The FNV-1a step is
// a shift-add network that completes in the parser cycle. There is no clearing pass
// after reset. Configuration writes are always taken and act at once.
module log_record_scanner_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input bytes.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // last_byte
  // Results.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] status, [13:3] record_index, [29:14] record_len, [44:30] end_offset,
  // [45] selected, [47:46] zero
  output logic [47:0] m_axis_tdata,
  output logic        m_axis_tuser,   // result_kind
  output logic        m_axis_tlast,   // run_last
  // Configuration writes.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_BODY    = 2'd1;
  localparam logic [1:0] PH_STOPPED = 2'd2;

  // Configuration registers.
  logic        strict_q;
  logic [15:0] maxlen_q;
  logic [10:0] sel_q;

  // Input register.
  logic        stage_v_q;
  logic [7:0]  byte_q;
  logic        last_q;

  // Parser state.
  logic [1:0]  phase_q, phase_d;
  logic [16:0] pos_q, pos_d;
  logic [63:0] hdr_q, hdr_d;
  logic [31:0] sum_q, sum_d;
  logic [14:0] rstart_q, rstart_d;
  logic [14:0] boff_q, boff_d;
  logic [11:0] total_q, total_d;

  // Parser outputs.
  logic [1:0]        n_push;
  lrs_pkg::result_t  res0, res1, end_res;
  logic [lrs_pkg::FIFO_CNT_W-1:0] fifo_cnt;
  lrs_pkg::result_t  head;

  logic        s_accept, pop;
  logic [lrs_pkg::FIFO_CNT_W:0] fill_need;

  // Parser intermediates.
  logic        last;
  logic [63:0] hdr_new;
  logic        ended, fin, fin_ok;
  logic [2:0]  end_status;
  logic [15:0] fin_len, len_b;
  logic [31:0] fin_sum, fin_chk, sum_upd;
  logic [16:0] fin_span;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strict_q <= 1'b0;
      maxlen_q <= 16'd256;
      sel_q    <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        lrs_pkg::CFG_STRICT: strict_q <= cfg_data_i[0];
        lrs_pkg::CFG_MAXLEN: maxlen_q <= cfg_data_i;
        lrs_pkg::CFG_SELECT: sel_q    <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  // Each byte in the input register writes at most two results next cycle.
  assign fill_need     = {1'b0, fifo_cnt} + {{(lrs_pkg::FIFO_CNT_W-1){1'b0}}, stage_v_q, 1'b0};
  assign s_axis_tready = fill_need <= (lrs_pkg::FIFO_CNT_W+1)'(lrs_pkg::FIFO_DEPTH - 2);
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_v_q <= 1'b0;
    end else begin
      stage_v_q <= s_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      byte_q <= s_axis_tdata;
      last_q <= s_axis_tlast;
    end
  end

  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    hdr_d      = hdr_q;
    sum_d      = sum_q;
    rstart_d   = rstart_q;
    boff_d     = boff_q + 15'd1;
    total_d    = total_q;
    ended      = 1'b0;
    end_status = lrs_pkg::ST_CLEAN;
    fin        = 1'b0;
    fin_ok     = 1'b0;
    fin_len    = hdr_q[31:16];
    fin_sum    = sum_q;
    fin_chk    = hdr_q[63:32];
    res0       = '0;
    res1       = '0;
    end_res    = '0;
    n_push     = 2'd0;

    // The byte at the top of the region closes the scan like a marked last byte.
    last    = last_q || (boff_q >= 15'(lrs_pkg::LOG_BYTES - 1));
    hdr_new = hdr_q | (64'(byte_q) << {pos_q[2:0], 3'b000});
    len_b   = hdr_q[31:16];
    sum_upd = lrs_pkg::fnv_step(sum_q, byte_q);

    unique case (phase_q)
      PH_HEADER: begin
        hdr_d = hdr_new;
        if (pos_q[2:0] != 3'd7) begin
          pos_d = pos_q + 17'd1;
          if (last) begin
            ended      = 1'b1;
            end_status = lrs_pkg::ST_CLEAN;
          end
        end else if (!strict_q && (hdr_new == '1)) begin
          ended      = 1'b1;
          end_status = lrs_pkg::ST_ERASED;
        end else if (hdr_new[15:0] != lrs_pkg::MAGIC_WORD) begin
          ended      = 1'b1;
          end_status = lrs_pkg::ST_BAD_MAGIC;
        end else if (strict_q && ((hdr_new[31:16] == 16'd0) || (hdr_new[31:16] > maxlen_q))) begin
          ended      = 1'b1;
          end_status = lrs_pkg::ST_BAD_LEN;
        end else if (hdr_new[31:16] == 16'd0) begin
          // An empty payload finishes the record with the header.
          fin     = 1'b1;
          fin_len = hdr_new[31:16];
          fin_chk = hdr_new[63:32];
        end else if (last) begin
          ended      = 1'b1;
          end_status = lrs_pkg::ST_OVERRUN;
        end else begin
          phase_d = PH_BODY;
          pos_d   = 17'd8;
        end
      end
      PH_BODY: begin
        // Padding bytes past the payload leave the checksum alone.
        if (pos_q < (17'd8 + {1'b0, len_b})) begin
          sum_d = sum_upd;
        end
        fin_sum = sum_d;
        if ((pos_q + 17'd1) >= lrs_pkg::span_of(len_b)) begin
          fin = 1'b1;
        end else begin
          pos_d = pos_q + 17'd1;
          if (last) begin
            ended      = 1'b1;
            end_status = lrs_pkg::ST_OVERRUN;
          end
        end
      end
      default: begin
        // Stopped: bytes are dropped until the region closes.
        boff_d = boff_q + 15'd1;
      end
    endcase

    fin_span = lrs_pkg::span_of(fin_len);
    if (fin) begin
      if (fin_sum != fin_chk) begin
        ended      = 1'b1;
        end_status = lrs_pkg::ST_BAD_SUM;
      end else begin
        fin_ok     = 1'b1;
        res0.kind  = lrs_pkg::KIND_RECORD;
        res0.status = lrs_pkg::ST_CLEAN;
        res0.idx   = total_q[10:0];
        res0.len   = fin_len;
        res0.off   = rstart_q + fin_span[14:0];
        res0.sel   = total_q[10:0] == sel_q;
        rstart_d   = rstart_q + fin_span[14:0];
        total_d    = (total_q != 12'hFFF) ? total_q + 12'd1 : total_q;
        phase_d    = PH_HEADER;
        pos_d      = '0;
        hdr_d      = '0;
        sum_d      = lrs_pkg::FNV_BASIS;
        if (last) begin
          // A record closed by the last byte is followed by a clean end.
          ended      = 1'b1;
          end_status = lrs_pkg::ST_CLEAN;
        end
      end
    end

    // End results report the state after any record finished by this byte.
    end_res.kind   = lrs_pkg::KIND_END;
    end_res.status = end_status;
    end_res.idx    = total_d[10:0];
    end_res.len    = '0;
    end_res.off    = rstart_d;
    end_res.sel    = 1'b0;
    end_res.rlast  = 1'b1;

    if (phase_q != PH_STOPPED) begin
      if (fin_ok && ended) begin
        res1   = end_res;
        n_push = 2'd2;
      end else if (fin_ok) begin
        res0.rlast = 1'b1;
        n_push     = 2'd1;
      end else if (ended) begin
        res0   = end_res;
        n_push = 2'd1;
      end
      if (ended && !last) begin
        phase_d = PH_STOPPED;
      end
    end

    // Closing the region rearms a fresh scan; a closing byte always ends a scan.
    if (last) begin
      phase_d  = PH_HEADER;
      pos_d    = '0;
      hdr_d    = '0;
      sum_d    = lrs_pkg::FNV_BASIS;
      rstart_d = '0;
      boff_d   = '0;
      total_d  = '0;
    end

    if (!stage_v_q) begin
      phase_d  = phase_q;
      pos_d    = pos_q;
      hdr_d    = hdr_q;
      sum_d    = sum_q;
      rstart_d = rstart_q;
      boff_d   = boff_q;
      total_d  = total_q;
      n_push   = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      pos_q    <= '0;
      hdr_q    <= '0;
      sum_q    <= lrs_pkg::FNV_BASIS;
      rstart_q <= '0;
      boff_q   <= '0;
      total_q  <= '0;
    end else begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      hdr_q    <= hdr_d;
      sum_q    <= sum_d;
      rstart_q <= rstart_d;
      boff_q   <= boff_d;
      total_q  <= total_d;
    end
  end

  lrs_result_fifo u_result_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (n_push),
    .push0_i    (res0),
    .push1_i    (res1),
    .pop_i      (pop),
    .head_o     (head),
    .count_o    (fifo_cnt)
  );

  assign m_axis_tvalid = fifo_cnt != '0;
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign m_axis_tdata  = {2'b00, head.sel, head.off, head.len, head.idx, head.status};
  assign m_axis_tuser  = head.kind;
  assign m_axis_tlast  = head.rlast;

  // The buffer never holds more than its depth.
  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_cnt <= lrs_pkg::FIFO_CNT_W'(lrs_pkg::FIFO_DEPTH))
    else $error("result buffer overfilled");

  // A stopped scan drops bytes without results.
  a_stopped_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stage_v_q && (phase_q == PH_STOPPED)) |-> (n_push == 2'd0))
    else $error("result from a stopped scan");

  // A pair of results is a record followed by a clean end that closes the beat group.
  a_pair_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (n_push == 2'd2) |-> ((res0.kind == lrs_pkg::KIND_RECORD) && !res0.rlast
                          && (res1.kind == lrs_pkg::KIND_END) && res1.rlast
                          && (res1.status == lrs_pkg::ST_CLEAN)))
    else $error("malformed result pair");

  // The payload phase always starts past the header.
  a_body_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_BODY) |-> (pos_q >= 17'd8))
    else $error("payload position inside header");

endmodule

FILE: tb/tb_log_record_scanner_unit.sv
// Testbench for the log record scanner: generated logs, a parser model and result checks.
module tb_log_record_scanner_unit;

  // Cycles without any beat on any channel before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 2000;
  // Cycles to let pass once nothing is expected.
  localparam int SETTLE_CYCLES = 6;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  typedef enum logic [1:0] {SCAN_HEADER, SCAN_BODY, SCAN_STOPPED} scan_phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } log_beat_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  log_record_scanner_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Log bytes waiting to be sent, and scan results waiting to come out of the block.
  log_beat_t          log_bytes_q[$];
  lrs_pkg::result_t   scan_results_q[$];

  int error_count;
  int result_count;
  int idle_cycles;
  logic byte_taken;

  // Idling: chance in percent per cycle that a burst starts, and what is left of one.
  int send_idle_pct;
  int take_idle_pct;
  int send_gap;
  int take_gap;

  // Register copies as the block should see them.
  logic        mode_strict;
  int          mode_max_len;
  logic [10:0] mode_select;

  // Parser state of the model.
  scan_phase_e scan_phase;
  int          rec_pos;
  logic [63:0] rec_header;
  logic [31:0] rec_sum;
  int          rec_start;
  int          region_offset;
  int          rec_total;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic report_error(string msg);
    error_count++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  function automatic logic [31:0] fnv_mix(logic [31:0] sum, logic [7:0] b);
    return (sum ^ {24'd0, b}) * FNV_PRIME;
  endfunction

  // Header, payload and padding up to the next 4-byte boundary.
  function automatic int span_bytes(int len);
    return (len + 11) & ~3;
  endfunction

  function void restart_scan();
    scan_phase    = SCAN_HEADER;
    rec_pos       = 0;
    rec_header    = '0;
    rec_sum       = lrs_pkg::FNV_BASIS;
    rec_start     = 0;
    region_offset = 0;
    rec_total     = 0;
  endfunction

  function void push_end(logic [2:0] status);
    lrs_pkg::result_t r;
    r        = '0;
    r.kind   = lrs_pkg::KIND_END;
    r.status = status;
    r.idx    = rec_total[10:0];
    r.off    = rec_start[14:0];
    scan_results_q.push_back(r);
  endfunction

  // Closes a record on its final byte; returns 1 when the checksum fails and the scan ends.
  function logic close_record();
    lrs_pkg::result_t r;
    int len;
    len = rec_header[31:16];
    if (rec_sum != rec_header[63:32]) begin
      push_end(lrs_pkg::ST_BAD_SUM);
      return 1'b1;
    end
    r        = '0;
    r.kind   = lrs_pkg::KIND_RECORD;
    r.status = lrs_pkg::ST_CLEAN;
    r.idx    = rec_total[10:0];
    r.len    = rec_header[31:16];
    r.off    = 15'(rec_start + span_bytes(len));
    r.sel    = (rec_total[10:0] == mode_select);
    scan_results_q.push_back(r);
    rec_start += span_bytes(len);
    if (rec_total < 4095) rec_total++;
    scan_phase = SCAN_HEADER;
    rec_pos    = 0;
    rec_header = '0;
    rec_sum    = lrs_pkg::FNV_BASIS;
    return 1'b0;
  endfunction

  // Advances the parser model by one accepted byte and queues the results it causes.
  function void parse_log_byte(logic [7:0] b, logic tlast);
    logic             closes;
    logic             ended;
    int               n;
    int               pos;
    int               len;
    lrs_pkg::result_t r;
    closes = tlast || (region_offset >= lrs_pkg::LOG_BYTES - 1);
    ended  = 1'b0;
    n      = 0;
    pos    = rec_pos;
    region_offset++;
    if (scan_phase == SCAN_STOPPED) begin
      // Bytes after a stop are dropped until the region closes.
      if (closes) restart_scan();
      return;
    end
    if (scan_phase == SCAN_HEADER) begin
      rec_header = rec_header | (64'(b) << (8 * (pos % 8)));
      if (pos < 7) begin
        rec_pos = pos + 1;
        if (closes) begin
          push_end(lrs_pkg::ST_CLEAN);
          ended = 1'b1;
          n++;
        end
      end else begin
        len = rec_header[31:16];
        if (!mode_strict && rec_header == '1) begin
          push_end(lrs_pkg::ST_ERASED);
          ended = 1'b1;
          n++;
        end else if (rec_header[15:0] != lrs_pkg::MAGIC_WORD) begin
          push_end(lrs_pkg::ST_BAD_MAGIC);
          ended = 1'b1;
          n++;
        end else if (mode_strict && (len == 0 || len > mode_max_len)) begin
          push_end(lrs_pkg::ST_BAD_LEN);
          ended = 1'b1;
          n++;
        end else if (span_bytes(len) == 8) begin
          ended = close_record();
          n++;
        end else if (closes) begin
          push_end(lrs_pkg::ST_OVERRUN);
          ended = 1'b1;
          n++;
        end else begin
          scan_phase = SCAN_BODY;
          rec_pos    = 8;
        end
      end
    end else begin
      len = rec_header[31:16];
      if (pos < 8 + len) rec_sum = fnv_mix(rec_sum, b);
      if (pos + 1 >= span_bytes(len)) begin
        ended = close_record();
        n++;
      end else begin
        rec_pos = pos + 1;
        if (closes) begin
          push_end(lrs_pkg::ST_OVERRUN);
          ended = 1'b1;
          n++;
        end
      end
    end
    // A record finished by the closing byte is followed by a clean end.
    if (!ended && closes && scan_phase == SCAN_HEADER && rec_pos == 0 && n > 0) begin
      push_end(lrs_pkg::ST_CLEAN);
      ended = 1'b1;
      n++;
    end
    if (ended) begin
      if (closes) restart_scan();
      else scan_phase = SCAN_STOPPED;
    end
    if (n > 0) begin
      r = scan_results_q.pop_back();
      r.rlast = 1'b1;
      scan_results_q.push_back(r);
    end
  endfunction

  function automatic string show_result(lrs_pkg::result_t r);
    return $sformatf("kind %0d status %0d idx %0d len %0d off %0d sel %0d last %0d",
                     r.kind, r.status, r.idx, r.len, r.off, r.sel, r.rlast);
  endfunction

  // ---------------------------------------------------------------------------
  // Log content generation.
  // ---------------------------------------------------------------------------

  function automatic void send_byte(logic [7:0] b, logic last);
    log_bytes_q.push_back(log_beat_t'{b, last});
  endfunction

  function automatic void put_raw_header(logic [63:0] h);
    for (int i = 0; i < 8; i++) send_byte(h[8*i +: 8], 1'b0);
  endfunction

  // Emits one record. With last_at at or above zero, the byte at that position of the
  // span carries the last flag and the record is cut there.
  function automatic void put_record(int len, logic sum_ok, int last_at);
    logic [7:0]  payload[$];
    logic [7:0]  p;
    logic [31:0] sum;
    logic [63:0] h;
    int          span;
    sum = lrs_pkg::FNV_BASIS;
    for (int i = 0; i < len; i++) begin
      p = 8'($urandom_range(0, 255));
      payload.push_back(p);
      sum = fnv_mix(sum, p);
    end
    if (!sum_ok) sum ^= 32'd1 << $urandom_range(0, 31);
    h    = {sum, 16'(len), lrs_pkg::MAGIC_WORD};
    span = span_bytes(len);
    for (int i = 0; i < span; i++) begin
      if (i < 8) p = h[8*i +: 8];
      else if (i < 8 + len) p = payload[i - 8];
      else p = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'hFF;
      send_byte(p, i == last_at);
      if (i == last_at) break;
    end
  endfunction

  // After a stop the region still has to be closed: either the stopping byte itself
  // carries the flag, or a few dropped bytes follow.
  function automatic void close_stopped_region();
    log_beat_t t;
    if ($urandom_range(0, 2) == 0) begin
      t = log_bytes_q.pop_back();
      t.last = 1'b1;
      log_bytes_q.push_back(t);
    end else begin
      repeat ($urandom_range(0, 5)) send_byte(8'($urandom_range(0, 255)), 1'b0);
      send_byte(8'($urandom_range(0, 255)), 1'b1);
    end
  endfunction

  // Mostly short payloads; now and then the configured limit or a few hundred bytes.
  function automatic int pick_len();
    int r;
    int len;
    r = $urandom_range(0, 9);
    if (r < 6) len = $urandom_range(0, 12);
    else if (r < 8) len = $urandom_range(13, 40);
    else if (r == 8) len = (mode_max_len > 300) ? $urandom_range(41, 300) : mode_max_len;
    else len = $urandom_range(41, 300);
    if (mode_strict && (len == 0 || len > mode_max_len)) len = (len % mode_max_len) + 1;
    return len;
  endfunction

  // One region: a few good records, then one way of ending the scan.
  function automatic void build_region();
    int len;
    repeat ($urandom_range(0, 3)) put_record(pick_len(), 1'b1, -1);
    case ($urandom_range(0, 7))
      0: begin
        // Record closed by the final byte of the region.
        len = pick_len();
        put_record(len, 1'b1, span_bytes(len) - 1);
      end
      1: begin
        // Erased header; in strict mode this is bad magic.
        put_raw_header('1);
        close_stopped_region();
      end
      2: begin
        put_raw_header({$urandom(), 16'($urandom_range(0, 1023)),
                        lrs_pkg::MAGIC_WORD ^ (16'd1 << $urandom_range(0, 15))});
        close_stopped_region();
      end
      3: begin
        // Length out of range for strict mode; in mount mode the length is not checked.
        if (mode_max_len < 1000 && $urandom_range(0, 1) == 1)
          len = mode_max_len + 1 + $urandom_range(0, 3);
        else len = 0;
        put_raw_header({$urandom(), 16'(len), lrs_pkg::MAGIC_WORD});
        close_stopped_region();
      end
      4: begin
        // Region ends from the last header byte up to the byte before the record's final byte.
        len = pick_len();
        if (len == 0) len = 1;
        put_record(len, 1'b1, $urandom_range(7, span_bytes(len) - 2));
      end
      5: begin
        put_record(pick_len(), 1'b0, -1);
        close_stopped_region();
      end
      6: begin
        // Region ends inside a header.
        put_record(pick_len(), 1'b1, $urandom_range(0, 6));
      end
      default: begin
        repeat ($urandom_range(0, 10)) send_byte(8'($urandom_range(0, 255)), 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b1);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Sequencing.
  // ---------------------------------------------------------------------------

  task automatic write_register(logic [1:0] index, logic [15:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (index)
      lrs_pkg::CFG_STRICT: mode_strict = value[0];
      lrs_pkg::CFG_MAXLEN: mode_max_len = value;
      lrs_pkg::CFG_SELECT: mode_select = value[10:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Waits until every byte is sent and every result has come out, then lets bytes
  // that cause no result clear the pipeline.
  task automatic wait_drained();
    while (log_bytes_q.size() != 0 || s_axis_tvalid || scan_results_q.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_phase(logic strict, int max_len, int select, int bytes,
                           int send_pct, int take_pct);
    int base;
    write_register(lrs_pkg::CFG_STRICT, 16'(strict));
    write_register(lrs_pkg::CFG_MAXLEN, 16'(max_len));
    write_register(lrs_pkg::CFG_SELECT, 16'(select));
    send_idle_pct = send_pct;
    take_idle_pct = take_pct;
    base = log_bytes_q.size();
    while (log_bytes_q.size() - base < bytes) build_region();
    wait_drained();
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = lrs_pkg::CFG_STRICT;
    cfg_data_i    = '0;
    error_count   = 0;
    result_count  = 0;
    idle_cycles   = 0;
    byte_taken    = 1'b0;
    send_idle_pct = 0;
    take_idle_pct = 0;
    send_gap      = 0;
    take_gap      = 0;
    mode_strict   = 1'b0;
    mode_max_len  = 256;
    mode_select   = '0;
    restart_scan();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed start in mount mode: a header cut short, a zero-length record closed by
    // the final byte (record and clean end), and an erased header followed by a
    // dropped closing byte.
    write_register(lrs_pkg::CFG_STRICT, 16'd0);
    write_register(lrs_pkg::CFG_MAXLEN, 16'd256);
    write_register(lrs_pkg::CFG_SELECT, 16'd0);
    send_idle_pct = 10;
    take_idle_pct = 10;
    send_byte(8'h47, 1'b0);
    send_byte(8'h4C, 1'b1);
    put_record(0, 1'b1, 7);
    put_raw_header('1);
    send_byte(8'h00, 1'b1);
    wait_drained();

    // Random regions under several register settings; the final phase runs without idling.
    run_phase(1'b0, 256, 0, 100, 15, 15);
    run_phase(1'b1, 1, $urandom_range(0, 2), 100, 0, 25);
    run_phase(1'b1, 65535, $urandom_range(0, 3), 100, 25, 0);
    run_phase(1'b1, $urandom_range(8, 64), $urandom_range(0, 2), 120, 15, 15);
    run_phase(1'b0, $urandom_range(1, 65535), 2047, 100, 20, 20);
    run_phase(1'b0, 256, $urandom_range(0, 3), 100, 0, 0);

    if (scan_results_q.size() != 0)
      report_error($sformatf("%0d results never arrived", scan_results_q.size()));
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Byte driver: holds a beat until it is taken, then sends the next one or idles.
  always @(negedge clk_i) begin
    log_beat_t beat;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || byte_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
        send_gap = $urandom_range(0, 13);
        s_axis_tvalid <= 1'b0;
      end else if (log_bytes_q.size() > 0) begin
        beat = log_bytes_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= beat.data;
        s_axis_tlast  <= beat.last;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: ready most of the time, with stall bursts.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (take_gap > 0) begin
      take_gap--;
      m_axis_tready <= 1'b0;
    end else if (take_idle_pct > 0 && $urandom_range(0, 99) < take_idle_pct) begin
      take_gap = $urandom_range(0, 13);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Monitor: checks each result beat against the oldest expected one, feeds each
  // accepted byte to the model and watches for a hung block.
  always @(posedge clk_i) begin
    lrs_pkg::result_t got;
    lrs_pkg::result_t want;
    logic             busy;
    byte_taken = 1'b0;
    if (rst_ni) begin
      busy = 1'b0;
      if (m_axis_tvalid && m_axis_tready) begin
        busy      = 1'b1;
        got.kind   = m_axis_tuser;
        got.status = m_axis_tdata[2:0];
        got.idx    = m_axis_tdata[13:3];
        got.len    = m_axis_tdata[29:14];
        got.off    = m_axis_tdata[44:30];
        got.sel    = m_axis_tdata[45];
        got.rlast  = m_axis_tlast;
        if (scan_results_q.size() == 0) begin
          report_error({"unexpected result: ", show_result(got)});
        end else begin
          want = scan_results_q.pop_front();
          if (got !== want)
            report_error($sformatf("result %0d: got %s, expected %s", result_count,
                                   show_result(got), show_result(want)));
        end
        result_count++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        busy       = 1'b1;
        byte_taken = 1'b1;
        parse_log_byte(s_axis_tdata, s_axis_tlast);
      end
      if (cfg_valid_i && cfg_ready_o) busy = 1'b1;
      if (busy) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        report_error($sformatf("timeout: no beat for %0d cycles, %0d results outstanding",
                               WATCHDOG_LIMIT, scan_results_q.size()));
        $display("== FAIL ==");
        $finish;
      end
    end
  end

endmodule
